>>> rtl/core/epcf_pkg.sv
// Shared types, constants and the quarter-sine weight table of the crossfader.
`default_nettype none

package epcf_pkg;

    localparam int CHANNELS           = 2;
    localparam int SINE_TABLE_ENTRIES = 1024;
    localparam int SAMPLE_BITS        = 24;

    localparam int WEIGHT_BITS  = 16;
    localparam int STEP_BITS    = 17;
    localparam int POS_BITS     = 17;
    localparam int LATENCY_BITS = 16;
    localparam int IDX_BITS     = $clog2(SINE_TABLE_ENTRIES + 1);

    localparam logic [POS_BITS-1:0] ONE_Q16       = POS_BITS'(65536);
    localparam logic [STEP_BITS-1:0] STEP_RESET   = STEP_BITS'(65536);
    localparam longint unsigned HALF_PI_Q30       = 64'd1686629713;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [WEIGHT_BITS-1:0] weight_t;
    typedef logic [IDX_BITS-1:0] tab_idx_t;
    typedef logic [LATENCY_BITS-1:0] latency_t;

    typedef struct packed {
        logic     start_fade;
        latency_t latency_before;
        latency_t latency_after;
        sample_t  old_left;
        sample_t  old_right;
        sample_t  new_left;
        sample_t  new_right;
    } in_word_t;

    typedef struct packed {
        sample_t  mix_left;
        sample_t  mix_right;
        logic     busy_res;
        latency_t current_latency;
    } out_word_t;

    // What the progress tracker reports for the word being accepted.
    typedef struct packed {
        logic     fading;
        logic     busy;
        latency_t latency;
        tab_idx_t idx;
    } prog_info_t;

    // Flags that travel down the pipeline next to the samples.
    typedef struct packed {
        logic     fading;
        logic     busy;
        latency_t latency;
    } word_tag_t;

    typedef weight_t sine_rom_t [SINE_TABLE_ENTRIES+1];

    // Q30 Taylor series of the sine, rounded to Q15; evaluated at elaboration only.
    function automatic weight_t sine_q15(input int unsigned k);
        longint unsigned x;
        longint unsigned x2;
        longint unsigned term;
        longint          sum;
        longint          r;
        x    = (longint'(k) * HALF_PI_Q30) / SINE_TABLE_ENTRIES;
        x2   = (x * x) >> 30;
        term = x;
        sum  = longint'(x);
        // Terms up to x^15; each divisor is (2n)(2n+1) of the series.
        term = ((term * x2) >> 30) / 64'd6;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd20;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd42;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd72;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd110;
        sum  = sum - longint'(term);
        term = ((term * x2) >> 30) / 64'd156;
        sum  = sum + longint'(term);
        term = ((term * x2) >> 30) / 64'd210;
        sum  = sum - longint'(term);
        if (sum < 0)
            sum = 0;
        r = (sum + 16384) >>> 15;
        if (r > 32767)
            r = 32767;
        return WEIGHT_BITS'(r);
    endfunction

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        for (int k = 0; k <= SINE_TABLE_ENTRIES; k++)
        begin
            rom[k] = sine_q15(k);
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

endpackage

`default_nettype wire

>>> rtl/core/epcf_progress.sv
// Fade progress accumulator, transition start logic and the fade step register.
`default_nettype none

module epcf_progress
    import epcf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [STEP_BITS-1:0] cfg_wr_data,
    input  wire logic                 accept,
    input  wire logic                 start_fade,
    input  wire latency_t             latency_before,
    input  wire latency_t             latency_after,
    output prog_info_t                info
);

    localparam int MUL_BITS = POS_BITS + IDX_BITS + 1;

    logic [STEP_BITS-1:0] fade_step_reg;
    logic [POS_BITS-1:0]  pos_reg, pos_next;
    logic                 fading_reg, fading_next;
    latency_t             target_reg, target_next;

    logic [POS_BITS-1:0]  pos_eff;
    logic                 fading_eff;
    logic [POS_BITS-1:0]  pos_clip;
    logic [MUL_BITS-1:0]  idx_prod;
    logic [MUL_BITS-1:0]  idx_full;
    logic [STEP_BITS-1:0] step_eff;
    logic [POS_BITS:0]    pos_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fade_step_reg <= STEP_RESET;
        end
        else if (cfg_wr_en)
        begin
            fade_step_reg <= cfg_wr_data;
        end
    end

    always_comb
    begin
        // A start restarts the progress before this word is blended.
        pos_eff     = start_fade ? '0 : pos_reg;
        fading_eff  = start_fade ? (latency_before != latency_after) : fading_reg;
        target_next = start_fade ? latency_after : target_reg;

        pos_clip = (pos_eff > ONE_Q16) ? ONE_Q16 : pos_eff;
        idx_prod = MUL_BITS'(pos_clip) * MUL_BITS'(SINE_TABLE_ENTRIES)
                   + MUL_BITS'(32768);
        idx_full = idx_prod >> 16;

        step_eff = (fade_step_reg == '0) ? STEP_BITS'(1) : fade_step_reg;
        pos_sum  = (POS_BITS+1)'(pos_eff) + (POS_BITS+1)'(step_eff);

        pos_next    = pos_eff;
        fading_next = fading_eff;
        if (fading_eff)
        begin
            if (pos_sum >= (POS_BITS+1)'(ONE_Q16))
            begin
                pos_next    = ONE_Q16;
                fading_next = 1'b0;
            end
            else
            begin
                pos_next = POS_BITS'(pos_sum);
            end
        end

        info.fading  = fading_eff;
        info.busy    = fading_next;
        info.latency = target_next;
        info.idx     = (idx_full > MUL_BITS'(SINE_TABLE_ENTRIES))
                       ? IDX_BITS'(SINE_TABLE_ENTRIES) : IDX_BITS'(idx_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            fading_reg <= 1'b0;
            target_reg <= '0;
        end
        else if (accept)
        begin
            pos_reg    <= pos_next;
            fading_reg <= fading_next;
            target_reg <= target_next;
        end
    end

`ifndef SYNTHESIS
    a_fading_below_one: assert property (@(posedge clk) disable iff (!rst_n)
        fading_reg |-> (pos_reg < ONE_Q16))
        else $error("fade still active with progress at one");

    a_idx_in_table: assert property (@(posedge clk) disable iff (!rst_n)
        info.idx <= IDX_BITS'(SINE_TABLE_ENTRIES))
        else $error("weight index beyond the table");
`endif

endmodule

`default_nettype wire

>>> rtl/core/epcf_weight_rom.sv
// Registered quarter-sine lookup giving the sine and cosine weights of one index.
`default_nettype none

module epcf_weight_rom
    import epcf_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     en,
    input  wire tab_idx_t idx,
    output weight_t       sin_w,
    output weight_t       cos_w
);

    tab_idx_t cos_idx;
    weight_t  sin_reg;
    weight_t  cos_reg;

    // The cosine of the angle is the sine of its complement.
    assign cos_idx = IDX_BITS'(SINE_TABLE_ENTRIES) - idx;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sin_reg <= SINE_ROM[idx];
            cos_reg <= SINE_ROM[cos_idx];
        end
    end

    assign sin_w = sin_reg;
    assign cos_w = cos_reg;

endmodule

`default_nettype wire

>>> rtl/core/epcf_lane.sv
// One channel lane: weighted products, rounding, saturation and pass-through.
`default_nettype none

module epcf_lane
    import epcf_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    mul_en,
    input  wire logic    out_en,
    input  wire logic    fading,
    input  wire weight_t cos_w,
    input  wire weight_t sin_w,
    input  wire sample_t old_sample,
    input  wire sample_t new_sample,
    output sample_t      mix
);

    localparam int PROD_BITS = SAMPLE_BITS + WEIGHT_BITS;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int RND_BITS  = SUM_BITS - 15;
    localparam logic signed [RND_BITS-1:0] SAT_HI =
        RND_BITS'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);
    localparam logic signed [RND_BITS-1:0] SAT_LO = ~SAT_HI;

    logic signed [PROD_BITS-1:0] prod_old_reg;
    logic signed [PROD_BITS-1:0] prod_new_reg;
    logic                        fading_reg;
    sample_t                     new_reg;

    logic signed [SUM_BITS-1:0]  sum;
    logic signed [SUM_BITS-1:0]  biased;
    logic signed [RND_BITS-1:0]  rounded;
    sample_t                     mix_next;
    sample_t                     mix_reg;

    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_old_reg <= PROD_BITS'(cos_w) * PROD_BITS'(old_sample);
            prod_new_reg <= PROD_BITS'(sin_w) * PROD_BITS'(new_sample);
            fading_reg   <= fading;
            new_reg      <= new_sample;
        end
    end

    always_comb
    begin
        sum     = SUM_BITS'(prod_old_reg) + SUM_BITS'(prod_new_reg);
        // Round to nearest with halves going up, then drop the Q15 fraction.
        biased  = sum + SUM_BITS'(16384);
        rounded = RND_BITS'(biased >>> 15);
        if (!fading_reg)
            mix_next = new_reg;
        else if (rounded > SAT_HI)
            mix_next = SAMPLE_BITS'(SAT_HI);
        else if (rounded < SAT_LO)
            mix_next = SAMPLE_BITS'(SAT_LO);
        else
            mix_next = SAMPLE_BITS'(rounded);
    end

    always_ff @(posedge clk)
    begin
        if (out_en)
        begin
            mix_reg <= mix_next;
        end
    end

    assign mix = mix_reg;

endmodule

`default_nettype wire

>>> rtl/core/equal_power_crossfader_unit.sv
// Top level of the equal-power crossfader: pipeline control, lanes and output word.
// A word accepted passes the s1, s2 and s3 registers and the output register in turn.
// Throughput: one stereo word per cycle while not stalled; the single progress accumulator
// updates at each accept, and the weight lookup and lane multipliers are fully pipelined.
// Reset (rst_n low, asynchronous): pipeline empty, fade idle at progress zero,
// stored latency zero, fade step set to one full fade per word.
`default_nettype none

module equal_power_crossfader_unit
    import epcf_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_wr_en,
    input  wire logic [STEP_BITS-1:0] cfg_wr_data,
    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire in_word_t             in_data,
    output logic                      out_valid,
    input  wire logic                 out_stall,
    output out_word_t                 out_data
);

    logic       accept;
    prog_info_t info;

    logic       s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic       go1, go2, go3, out_ready;

    tab_idx_t   s1_idx_reg;
    word_tag_t  s1_tag_reg, s2_tag_reg, s3_tag_reg;
    sample_t    s1_old_reg [CHANNELS];
    sample_t    s1_new_reg [CHANNELS];
    sample_t    s2_old_reg [CHANNELS];
    sample_t    s2_new_reg [CHANNELS];
    sample_t    in_old [CHANNELS];
    sample_t    in_new [CHANNELS];
    sample_t    lane_mix [CHANNELS];
    weight_t    sin_w, cos_w;
    logic       out_busy_reg;
    latency_t   out_latency_reg;

    // Each stage may load when it is empty or the stage after it moves on.
    assign out_ready = !out_valid_reg || !out_stall;
    assign go3       = !s3_valid_reg || out_ready;
    assign go2       = !s2_valid_reg || go3;
    assign go1       = !s1_valid_reg || go2;
    assign in_stall  = !go1;
    assign accept    = in_valid && go1;

    epcf_progress u_progress (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .accept         (accept),
        .start_fade     (in_data.start_fade),
        .latency_before (in_data.latency_before),
        .latency_after  (in_data.latency_after),
        .info           (info)
    );

    assign in_old[0] = in_data.old_left;
    assign in_new[0] = in_data.new_left;
    generate
        if (CHANNELS > 1)
        begin : g_right_in
            assign in_old[1] = in_data.old_right;
            assign in_new[1] = in_data.new_right;
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (go1)
                s1_valid_reg <= accept;
            if (go2)
                s2_valid_reg <= s1_valid_reg;
            if (go3)
                s3_valid_reg <= s2_valid_reg;
            if (out_ready)
                out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1)
        begin
            s1_idx_reg        <= info.idx;
            s1_tag_reg.fading <= info.fading;
            s1_tag_reg.busy   <= info.busy;
            s1_tag_reg.latency <= info.latency;
            s1_old_reg        <= in_old;
            s1_new_reg        <= in_new;
        end
        if (go2)
        begin
            s2_tag_reg <= s1_tag_reg;
            s2_old_reg <= s1_old_reg;
            s2_new_reg <= s1_new_reg;
        end
        if (go3)
        begin
            s3_tag_reg <= s2_tag_reg;
        end
    end

    epcf_weight_rom u_weight_rom (
        .clk   (clk),
        .en    (go2),
        .idx   (s1_idx_reg),
        .sin_w (sin_w),
        .cos_w (cos_w)
    );

    generate
        for (genvar ch = 0; ch < CHANNELS; ch++)
        begin : g_lane
            epcf_lane u_lane (
                .clk        (clk),
                .mul_en     (go3),
                .out_en     (out_ready),
                .fading     (s2_tag_reg.fading),
                .cos_w      (cos_w),
                .sin_w      (sin_w),
                .old_sample (s2_old_reg[ch]),
                .new_sample (s2_new_reg[ch]),
                .mix        (lane_mix[ch])
            );
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (out_ready)
        begin
            out_busy_reg    <= s3_tag_reg.busy;
            out_latency_reg <= s3_tag_reg.latency;
        end
    end

    always_comb
    begin
        out_data.mix_left        = lane_mix[0];
        out_data.mix_right       = '0;
        out_data.busy_res        = out_busy_reg;
        out_data.current_latency = out_latency_reg;
        if (CHANNELS > 1)
            out_data.mix_right = lane_mix[CHANNELS-1];
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_empty_output_takes_word: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while the output register is empty");

    a_equal_latency_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.start_fade
            && (in_data.latency_before == in_data.latency_after))
        |=> (s1_valid_reg && !s1_tag_reg.busy && !s1_tag_reg.fading))
        else $error("transition with equal latencies started a fade");

    a_latency_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && in_data.start_fade)
        |=> (s1_tag_reg.latency == $past(in_data.latency_after)))
        else $error("stored latency does not follow the transition start");
`endif

endmodule

`default_nettype wire

>>> tb/tb_equal_power_crossfader_unit.sv
// Self-checking testbench of the equal-power crossfader with a cycle-free mix predictor.
`timescale 1ns / 100ps

module tb_equal_power_crossfader_unit;
    import epcf_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PIPE_LATENCY = 3;
    localparam int N_TAB        = SINE_TABLE_ENTRIES;
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_wr_en = 1'b0;
    logic [STEP_BITS-1:0] cfg_wr_data = '0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    in_word_t             in_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    out_word_t            out_data;

    // Predictor state, kept apart from the block.
    int            quarter_sine_tab [N_TAB+1];
    int unsigned   step_reg;
    int unsigned   progress;
    bit            in_fade;
    latency_t      held_latency;

    out_word_t     mix_expected [$];
    out_word_t     exp_word;
    int            errors = 0;
    int            frames_sent = 0;
    int            words_checked = 0;
    int            fades_started = 0;
    int            steps_written = 0;
    int            cycles = 0;
    bit            gaps_on = 1'b0;
    bit            stall_on = 1'b0;
    int            stall_hold = 0;
    int            stall_roll;

    equal_power_crossfader_unit u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Q30 Taylor sine of the k-th quarter-wave point, rounded to Q15.
    function automatic int sine_weight(int unsigned k);
        longint unsigned ang;
        longint unsigned ang_sq;
        longint unsigned t;
        longint          acc;
        longint          q;
        ang    = (longint'(k) * 64'd1686629713) / N_TAB;
        ang_sq = (ang * ang) >> 30;
        t      = ang;
        acc    = longint'(ang);
        for (int n = 1; n <= 7; n++)
        begin
            t = ((t * ang_sq) >> 30) / longint'((2 * n) * (2 * n + 1));
            acc = (n % 2 == 1) ? acc - longint'(t) : acc + longint'(t);
        end
        if (acc < 0)
            acc = 0;
        q = (acc + 16384) >>> 15;
        return (q > 32767) ? 32767 : int'(q);
    endfunction

    function automatic sample_t clamp_sample(longint v);
        if (v > longint'(S_MAX))
            return S_MAX;
        if (v < longint'(S_MIN))
            return S_MIN;
        return sample_t'(v);
    endfunction

    function automatic sample_t mix_lane(int cw, int sw, sample_t o, sample_t n);
        longint acc;
        if (!in_fade)
            return n;
        acc = longint'(cw) * longint'($signed(o)) + longint'(sw) * longint'($signed(n));
        // Arithmetic shift floors, so halves round toward plus infinity.
        return clamp_sample((acc + 16384) >>> 15);
    endfunction

    // Works out the mixed word for one accepted frame and advances the fade.
    function automatic out_word_t blend_frame(in_word_t w);
        out_word_t   r;
        int unsigned p;
        int unsigned idx;
        if (w.start_fade)
        begin
            held_latency = w.latency_after;
            progress = 0;
            in_fade = (w.latency_before != w.latency_after);
            if (in_fade)
                fades_started++;
        end
        p = (progress > 65536) ? 65536 : progress;
        idx = (p * N_TAB + 32768) >> 16;
        if (idx > N_TAB)
            idx = N_TAB;
        r.mix_left  = mix_lane(quarter_sine_tab[N_TAB-idx], quarter_sine_tab[idx],
                               w.old_left, w.new_left);
        r.mix_right = mix_lane(quarter_sine_tab[N_TAB-idx], quarter_sine_tab[idx],
                               w.old_right, w.new_right);
        if (in_fade)
        begin
            progress = progress + ((step_reg == 0) ? 1 : step_reg);
            if (progress >= 65536)
            begin
                progress = 65536;
                in_fade = 1'b0;
            end
        end
        r.busy_res = in_fade;
        r.current_latency = held_latency;
        return r;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
            mix_expected.push_back(blend_frame(in_data));
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            words_checked++;
            if (mix_expected.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word %h", $time, out_data);
            end
            else
            begin
                exp_word = mix_expected.pop_front();
                if (out_data.mix_left !== exp_word.mix_left)
                begin
                    errors++;
                    $display("%0t: mix_left expected %0d actual %0d", $time,
                             exp_word.mix_left, out_data.mix_left);
                end
                if (out_data.mix_right !== exp_word.mix_right)
                begin
                    errors++;
                    $display("%0t: mix_right expected %0d actual %0d", $time,
                             exp_word.mix_right, out_data.mix_right);
                end
                if (out_data.busy_res !== exp_word.busy_res)
                begin
                    errors++;
                    $display("%0t: busy_res expected %0b actual %0b", $time,
                             exp_word.busy_res, out_data.busy_res);
                end
                if (out_data.current_latency !== exp_word.current_latency)
                begin
                    errors++;
                    $display("%0t: current_latency expected %0d actual %0d", $time,
                             exp_word.current_latency, out_data.current_latency);
                end
            end
        end
    end

    // Output back-pressure: mostly none, some short stalls, now and then a long one.
    always @(posedge clk)
    begin
        if (!stall_on)
            out_stall <= 1'b0;
        else if (stall_hold > 0)
        begin
            stall_hold--;
            out_stall <= 1'b1;
        end
        else
        begin
            stall_roll = $urandom_range(0, 99);
            if (stall_roll < 70)
                out_stall <= 1'b0;
            else if (stall_roll < 95)
            begin
                stall_hold = $urandom_range(0, 3);
                out_stall <= 1'b1;
            end
            else
            begin
                stall_hold = $urandom_range(10, 40);
                out_stall <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

    function automatic int next_gap();
        int r;
        r = $urandom_range(0, 99);
        if (!gaps_on || r < 65)
            return 0;
        if (r < 95)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // Entered and left just after a rising edge; valid stays high between back-to-back words.
    task automatic send_frame(in_word_t w);
        int gap;
        in_data <= w;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        frames_sent++;
        gap = next_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (mix_expected.size() != 0);
        repeat (PIPE_LATENCY + 1) @(posedge clk);
    endtask

    task automatic write_step(int unsigned v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= STEP_BITS'(v);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        step_reg = v;
        steps_written++;
    endtask

    function automatic in_word_t make_frame(bit st, latency_t lb, latency_t la,
                                            sample_t ol, sample_t orr,
                                            sample_t nl, sample_t nr);
        in_word_t w;
        w.start_fade = st;
        w.latency_before = lb;
        w.latency_after = la;
        w.old_left = ol;
        w.old_right = orr;
        w.new_left = nl;
        w.new_right = nr;
        return w;
    endfunction

    function automatic sample_t rand_sample();
        case ($urandom_range(0, 19))
            0: return S_MAX;
            1: return S_MIN;
            2: return '0;
            3: return '1;
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic in_word_t rand_frame(int start_pct);
        in_word_t w;
        w.start_fade = ($urandom_range(0, 99) < start_pct);
        w.latency_before = latency_t'($urandom);
        w.latency_after = ($urandom_range(0, 3) == 0) ? w.latency_before
                                                      : latency_t'($urandom);
        w.old_left = rand_sample();
        w.old_right = rand_sample();
        w.new_left = rand_sample();
        w.new_right = rand_sample();
        return w;
    endfunction

    task automatic test_idle_passthrough();
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MIN, S_MAX, S_MAX, S_MIN));
        send_frame(make_frame(1'b0, 16'hFFFF, 16'hFFFF, S_MAX, S_MIN, S_MIN, S_MAX));
        // Equal latencies on start: the latency is taken but no fade begins.
        send_frame(make_frame(1'b1, 16'hFFFF, 16'hFFFF, S_MAX, S_MAX, '0, '1));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, '1, '0, 24'sd1, -24'sd1));
    endtask

    task automatic test_full_step_fade();
        // Reset step is a whole fade per frame: one blended frame, then idle.
        send_frame(make_frame(1'b1, 16'd0, 16'hFFFF, S_MAX, S_MIN, S_MIN, S_MAX));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MAX, S_MAX, 24'sd12345, -24'sd777));
    endtask

    task automatic test_midpoint_saturation();
        write_step(32768);
        send_frame(make_frame(1'b1, 16'hFFFF, 16'd0, S_MAX, S_MAX, S_MAX, S_MAX));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MAX, S_MAX, S_MAX, S_MAX));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MIN, S_MIN, S_MIN, S_MIN));
        write_step(21845);
        send_frame(make_frame(1'b1, 16'd1, 16'd2, S_MIN, S_MAX, S_MIN, S_MAX));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MIN, S_MAX, S_MIN, S_MAX));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MIN, 24'sd1, S_MIN, -24'sd1));
    endtask

    task automatic test_step_extremes();
        write_step(65535);
        send_frame(make_frame(1'b1, 16'd5, 16'd6, S_MAX, S_MIN, 24'sd100, -24'sd100));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MAX, S_MIN, S_MIN, S_MAX));
        // Largest step: progress is clamped at one after the first frame.
        write_step(131071);
        send_frame(make_frame(1'b1, 16'd7, 16'd3, S_MIN, S_MAX, S_MAX, S_MIN));
        send_frame(make_frame(1'b0, 16'd7, 16'd3, S_MIN, S_MAX, S_MAX, S_MIN));
        // Zero step acts as one; an equal-latency start cuts the fade short.
        write_step(0);
        send_frame(make_frame(1'b1, 16'd0, 16'd1, S_MAX, S_MAX, S_MIN, S_MIN));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MAX, S_MAX, S_MIN, S_MIN));
        send_frame(make_frame(1'b1, 16'd9, 16'd9, S_MAX, S_MAX, S_MIN, S_MIN));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MAX, S_MIN, S_MIN, S_MAX));
        // Restart in the middle of a slow fade.
        write_step(1);
        send_frame(make_frame(1'b1, 16'd4, 16'd8, S_MAX, S_MIN, '0, '0));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, S_MAX, S_MIN, '0, '0));
        send_frame(make_frame(1'b1, 16'd8, 16'd4, '0, '0, S_MAX, S_MIN));
        send_frame(make_frame(1'b0, 16'd0, 16'd0, '1, '1, S_MAX, S_MIN));
    endtask

    task automatic test_random_fades();
        int unsigned step_val;
        for (int ph = 0; ph < 10; ph++)
        begin
            case ($urandom_range(0, 5))
                0: step_val = $urandom_range(1, 2048);
                1: step_val = $urandom_range(2049, 16384);
                2: step_val = $urandom_range(16385, 65535);
                3: step_val = 65536;
                4: step_val = $urandom_range(65537, 131071);
                default: step_val = $urandom_range(1024, 8192);
            endcase
            if (ph == 9)
                step_val = 0;
            write_step(step_val);
            // The first phase runs with no gaps and no back-pressure.
            gaps_on = (ph != 0);
            stall_on = (ph != 0);
            for (int i = 0; i < 75; i++)
            begin
                send_frame(rand_frame((step_val > 8192) ? 15 : 4));
                if ($urandom_range(0, 99) == 0)
                    drain();
            end
        end
        stall_on = 1'b0;
    endtask

    initial
    begin
        for (int k = 0; k <= N_TAB; k++)
            quarter_sine_tab[k] = sine_weight(k);
        step_reg = 65536;
        progress = 0;
        in_fade = 1'b0;
        held_latency = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_idle_passthrough();
        test_full_step_fade();
        test_midpoint_saturation();
        test_step_extremes();
        test_random_fades();

        in_valid <= 1'b0;
        for (int w = 0; w < 2000 && mix_expected.size() != 0; w++)
            @(posedge clk);
        repeat (PIPE_LATENCY + 8) @(posedge clk);
        if (mix_expected.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected words never arrived", $time, mix_expected.size());
        end

        $display("Sent %0d frames and checked %0d mixed words; %0d fades started.",
                 frames_sent, words_checked, fades_started);
        $display("Fade step was reprogrammed %0d times; %0d mismatches seen.",
                 steps_written, errors);
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

>>> files.f
rtl/core/epcf_pkg.sv
rtl/core/epcf_progress.sv
rtl/core/epcf_weight_rom.sv
rtl/core/epcf_lane.sv
rtl/core/equal_power_crossfader_unit.sv
tb/tb_equal_power_crossfader_unit.sv
